>>> src/wfvd_pkg.sv
// ----------------------------------------------------------------------------
// wfvd_pkg
// Types and constants shared by the wire field decoder modules.
// ----------------------------------------------------------------------------
package wfvd_pkg;

    localparam int unsigned MAX_VARINT_BYTES = 10;
    localparam int unsigned LEN_W            = 31;

    localparam logic [LEN_W-1:0] MAX_ARRAY_LENGTH_RST = 31'd104857600;

    // Field type codes as they arrive on the mode field.
    localparam logic [2:0] MODE_I8      = 3'd0;
    localparam logic [2:0] MODE_I16     = 3'd1;
    localparam logic [2:0] MODE_I32     = 3'd2;
    localparam logic [2:0] MODE_I64     = 3'd3;
    localparam logic [2:0] MODE_VARINT  = 3'd4;
    localparam logic [2:0] MODE_UVARINT = 3'd5;
    localparam logic [2:0] MODE_BOOL    = 3'd6;
    localparam logic [2:0] MODE_ARRAY   = 3'd7;

    // Field type held while a field is open: the mode, with a top bit set for a compact array.
    localparam logic [3:0] AM_I8          = 4'd0;
    localparam logic [3:0] AM_I16         = 4'd1;
    localparam logic [3:0] AM_I32         = 4'd2;
    localparam logic [3:0] AM_I64         = 4'd3;
    localparam logic [3:0] AM_VARINT      = 4'd4;
    localparam logic [3:0] AM_UVARINT     = 4'd5;
    localparam logic [3:0] AM_BOOL        = 4'd6;
    localparam logic [3:0] AM_FIXED_LEN   = 4'd7;
    localparam logic [3:0] AM_COMPACT_LEN = 4'd15;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_DATA     = 3'd1,
        ST_VARINT_OVF  = 3'd2,
        ST_UVARINT_OVF = 3'd3,
        ST_BAD_BOOL    = 3'd4,
        ST_BAD_LEN     = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [2:0] mode;
        logic       compact;
        logic       no_data;
    } item_t;

    typedef struct packed {
        logic [63:0] acc;
        logic [3:0]  cnt;
        logic [3:0]  amode;
        logic        open;
    } fstate_t;

    typedef struct packed {
        logic [63:0] value;
        status_t     status;
        logic [3:0]  bytes_used;
    } result_t;

endpackage

>>> src/wfvd_if.sv
// ----------------------------------------------------------------------------
// wfvd_if
// Valid/ready channels for the byte stream and for the decoded fields.
// ----------------------------------------------------------------------------
interface wfvd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [2:0] mode;
    logic       compact;
    logic       no_data;

    modport source (output valid, data_byte, mode, compact, no_data, input ready);
    modport sink   (input valid, data_byte, mode, compact, no_data, output ready);
endinterface

interface wfvd_field_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] value;
    logic [2:0]         status;
    logic [3:0]         bytes_used;

    modport source (output valid, value, status, bytes_used, input ready);
    modport sink   (input valid, value, status, bytes_used, output ready);
endinterface

>>> src/wfvd_step.sv
// ----------------------------------------------------------------------------
// wfvd_step
// Per-byte decode: folds one byte into the field state and forms the result.
// ----------------------------------------------------------------------------
module wfvd_step
    import wfvd_pkg::*;
(
    input  item_t            item,
    input  fstate_t          cur,
    input  logic [LEN_W-1:0] max_len,
    output fstate_t          nxt,
    output logic             emit,
    output result_t          res
);

    logic [3:0]  am;
    logic [63:0] acc0;
    logic [3:0]  cnt0;
    logic [3:0]  cnt1;
    logic [3:0]  need;
    logic [63:0] acc_s;
    logic [63:0] acc_v;
    logic [6:0]  shift;
    logic [6:0]  payload;
    logic        last;
    logic [31:0] dec;

    always_comb
    begin
        am      = cur.open ? cur.amode : {item.mode == MODE_ARRAY && item.compact, item.mode};
        acc0    = cur.open ? cur.acc : 64'd0;
        cnt0    = cur.open ? cur.cnt : 4'd0;
        cnt1    = cnt0 + 4'd1;
        acc_s   = {acc0[55:0], item.data_byte};
        payload = item.data_byte[6:0];
        shift   = {cnt0, 3'b000} - {3'b000, cnt0};
        acc_v   = acc0;
        if (shift < 7'd64)
        begin
            acc_v = acc0 | ({57'd0, payload} << shift[5:0]);
        end
        last = cnt1 >= 4'(MAX_VARINT_BYTES);
        dec  = acc_v[31:0] - 32'd1;

        case (am)
            AM_I8:        need = 4'd1;
            AM_I16:       need = 4'd2;
            AM_I32:       need = 4'd4;
            AM_I64:       need = 4'd8;
            AM_FIXED_LEN: need = 4'd4;
            default:      need = 4'd0;
        endcase

        nxt.amode = am;
        nxt.cnt   = cnt1;
        nxt.acc   = acc0;
        emit      = 1'b0;
        res.value      = 64'd0;
        res.status     = ST_OK;
        res.bytes_used = cnt1;

        if (item.no_data)
        begin
            // The field fails with the bytes taken so far.
            emit           = 1'b1;
            res.status     = ST_NO_DATA;
            res.bytes_used = cnt0;
            if (am <= AM_VARINT || am == AM_FIXED_LEN)
            begin
                res.value = '1;
            end
        end
        else
        begin
            case (am)
                AM_I8, AM_I16, AM_I32, AM_I64, AM_FIXED_LEN:
                begin
                    nxt.acc = acc_s;
                    if (cnt1 >= need)
                    begin
                        emit = 1'b1;
                        case (am)
                            AM_I8:   res.value = {{56{acc_s[7]}}, acc_s[7:0]};
                            AM_I16:  res.value = {{48{acc_s[15]}}, acc_s[15:0]};
                            AM_I64:  res.value = acc_s;
                            default: res.value = {{32{acc_s[31]}}, acc_s[31:0]};
                        endcase
                        // A negative fixed length passes the limit check.
                        if (am == AM_FIXED_LEN && !acc_s[31] && acc_s[30:0] > max_len)
                        begin
                            res.value  = '1;
                            res.status = ST_BAD_LEN;
                        end
                    end
                end
                AM_BOOL:
                begin
                    emit           = 1'b1;
                    res.bytes_used = 4'd1;
                    if (item.data_byte <= 8'd1)
                    begin
                        res.value = {56'd0, item.data_byte};
                    end
                    else
                    begin
                        res.status = ST_BAD_BOOL;
                    end
                end
                AM_VARINT, AM_UVARINT, AM_COMPACT_LEN:
                begin
                    nxt.acc = acc_v;
                    if (!item.data_byte[7])
                    begin
                        emit = 1'b1;
                        if (am == AM_VARINT)
                        begin
                            if (last && payload > 7'd1)
                            begin
                                res.value  = '1;
                                res.status = ST_VARINT_OVF;
                            end
                            else
                            begin
                                res.value = {1'b0, acc_v[63:1]} ^ {64{acc_v[0]}};
                            end
                        end
                        else if (last && acc_v[63])
                        begin
                            res.status = ST_UVARINT_OVF;
                        end
                        else if (am == AM_UVARINT)
                        begin
                            res.value = acc_v;
                        end
                        else if (acc_v != 64'd0)
                        begin
                            res.value = {{32{dec[31]}}, dec};
                        end
                    end
                    else if (last)
                    begin
                        emit = 1'b1;
                        if (am == AM_VARINT)
                        begin
                            res.value  = '1;
                            res.status = ST_VARINT_OVF;
                        end
                        else
                        begin
                            res.status = ST_UVARINT_OVF;
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        nxt.open = !emit;
    end

endmodule

>>> src/wire_field_varint_decoder_core.sv
// ----------------------------------------------------------------------------
// wire_field_varint_decoder_core
// Decodes big-endian integers, varints, booleans and array lengths from a
// message byte stream, one byte per beat, one result beat per field.
//
//   channel  dir  payload                               beat
//   stream   in   data_byte, mode, compact, no_data     one byte or end mark
//   field    out  value, status, bytes_used             one finished field
//   cfg      in   cfg_wr_en, cfg_wr_data                max_array_length
//
// One stream beat is taken every cycle while the result register is free or
// being emptied. A byte is held in the input register, is decoded there, and
// its result is registered in the output register when the byte advances.
// A stall on field holds the decoded beat and the input register; stream
// accepts again as soon as that beat leaves.
// Reset clears the field state and restores the length limit.
// ----------------------------------------------------------------------------
module wire_field_varint_decoder_core
    import wfvd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data,
    wfvd_byte_if.sink           stream,
    wfvd_field_if.source        field
);

    logic             in_valid_reg;
    item_t            in_item_reg;
    fstate_t          fstate_reg;
    logic [LEN_W-1:0] max_len_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;

    fstate_t          fstate_next;
    logic             out_valid_next;
    logic             step_emit;
    result_t          step_res;
    logic             advance;

    wfvd_step u_step (
        .item    (in_item_reg),
        .cur     (fstate_reg),
        .max_len (max_len_reg),
        .nxt     (fstate_next),
        .emit    (step_emit),
        .res     (step_res)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || field.ready);
    assign stream.ready = !in_valid_reg || advance;

    always_comb
    begin
        if (advance && step_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (field.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fstate_reg    <= '0;
            max_len_reg   <= MAX_ARRAY_LENGTH_RST;
        end
        else
        begin
            if (stream.ready)
            begin
                in_valid_reg <= stream.valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                fstate_reg <= fstate_next;
            end
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            in_item_reg.data_byte <= stream.data_byte;
            in_item_reg.mode      <= stream.mode;
            in_item_reg.compact   <= stream.compact;
            in_item_reg.no_data   <= stream.no_data;
        end
        if (advance && step_emit)
        begin
            out_res_reg <= step_res;
        end
    end

    assign field.valid      = out_valid_reg;
    assign field.value      = out_res_reg.value;
    assign field.status     = out_res_reg.status;
    assign field.bytes_used = out_res_reg.bytes_used;

`ifndef SYNTHESIS
    // An open field has taken between one and nine bytes.
    a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
        fstate_reg.open |-> (fstate_reg.cnt != 4'd0 && fstate_reg.cnt < 4'd10))
        else $error("open field with impossible byte count");

    // A decoded byte that closes nothing leaves the field open.
    a_stay_open: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !step_emit |=> fstate_reg.open)
        else $error("field closed without a result");

    // Only an end mark on a requested field gives a result with no bytes.
    a_zero_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.bytes_used == 4'd0 |-> out_res_reg.status == ST_NO_DATA)
        else $error("zero-byte result that is not insufficient data");

    // Results never report more than the varint limit.
    a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_res_reg.bytes_used <= 4'(MAX_VARINT_BYTES))
        else $error("bytes_used above varint limit");
`endif

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wire field decoder. Whole fields and loose
// noise beats are streamed in under random bursts and result stalls, the
// decoded value, status and byte count of each field are predicted here and
// compared in order, and the array length limit is moved between phases.
// ----------------------------------------------------------------------------
module tb_top
    import wfvd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Keeps a copy of the decoder state and the fields that are due out.
    class field_scoreboard;
        logic [63:0]     acc;
        logic [3:0]      cnt;
        logic [3:0]      amode;
        bit              in_field;
        logic [LEN_W-1:0] max_len;
        result_t         due_fields[$];
        int              n_bad;
        int              n_checked;

        function new();
            acc       = '0;
            cnt       = '0;
            amode     = '0;
            in_field  = 1'b0;
            max_len   = MAX_ARRAY_LENGTH_RST;
            n_bad     = 0;
            n_checked = 0;
        endfunction

        function logic [63:0] sign_ext(logic [63:0] v, int unsigned n);
            logic signed [63:0] t;
            t = v << (64 - n);
            return t >>> (64 - n);
        endfunction

        function void finish_field(logic [63:0] v, status_t st);
            result_t r;
            r.value      = v;
            r.status     = st;
            r.bytes_used = cnt;
            due_fields   = {due_fields, r};
            in_field = 1'b0;
        endfunction

        function void decode_byte(item_t it);
            logic [63:0] pay;
            logic [31:0] len;
            int unsigned need;
            if (!in_field)
            begin
                amode    = (it.mode == MODE_ARRAY && it.compact) ? AM_COMPACT_LEN
                                                                 : {1'b0, it.mode};
                acc      = '0;
                cnt      = '0;
                in_field = 1'b1;
            end
            if (it.no_data)
            begin
                finish_field((amode <= AM_VARINT || amode == AM_FIXED_LEN) ? {64{1'b1}}
                                                                           : 64'd0,
                             ST_NO_DATA);
                return;
            end
            cnt = cnt + 4'd1;
            case (amode)
                AM_I8, AM_I16, AM_I32, AM_I64, AM_FIXED_LEN:
                begin
                    need = (amode == AM_FIXED_LEN) ? 4 : (1 << amode);
                    acc  = {acc[55:0], it.data_byte};
                    if (cnt == need)
                    begin
                        len = acc[31:0];
                        if (amode != AM_FIXED_LEN)
                            finish_field(sign_ext(acc, 8 * need), ST_OK);
                        else if (!len[31] && len > {1'b0, max_len})
                            finish_field({64{1'b1}}, ST_BAD_LEN);
                        else
                            finish_field(sign_ext({32'd0, len}, 32), ST_OK);
                    end
                end
                AM_BOOL:
                begin
                    if (it.data_byte <= 8'd1)
                        finish_field({56'd0, it.data_byte}, ST_OK);
                    else
                        finish_field(64'd0, ST_BAD_BOOL);
                end
                AM_VARINT, AM_UVARINT, AM_COMPACT_LEN:
                begin
                    pay = {57'd0, it.data_byte[6:0]};
                    // The tenth byte lands at bit 63, so only its lowest bit survives.
                    acc = acc | (pay << (7 * (cnt - 1)));
                    if (!it.data_byte[7])
                    begin
                        if (amode == AM_VARINT)
                        begin
                            if (cnt >= MAX_VARINT_BYTES && pay > 64'd1)
                                finish_field({64{1'b1}}, ST_VARINT_OVF);
                            else
                                finish_field((acc >> 1) ^ {64{acc[0]}}, ST_OK);
                        end
                        else if (cnt >= MAX_VARINT_BYTES && acc[63])
                            finish_field(64'd0, ST_UVARINT_OVF);
                        else if (amode == AM_UVARINT)
                            finish_field(acc, ST_OK);
                        else if (acc == 64'd0)
                            finish_field(64'd0, ST_OK);
                        else
                            finish_field(sign_ext(acc - 64'd1, 32), ST_OK);
                    end
                    else if (cnt >= MAX_VARINT_BYTES)
                    begin
                        if (amode == AM_VARINT)
                            finish_field({64{1'b1}}, ST_VARINT_OVF);
                        else
                            finish_field(64'd0, ST_UVARINT_OVF);
                    end
                end
                default:
                    in_field = 1'b0;
            endcase
        endfunction

        function void check_field(logic [63:0] v, logic [2:0] st, logic [3:0] used);
            result_t e;
            n_checked++;
            if (due_fields.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: field result with none due: value %h status %0d used %0d",
                             v, st, used);
                return;
            end
            e = due_fields.pop_front();
            if (v !== e.value || st !== e.status || used !== e.bytes_used)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("ERROR: expected value %h status %0d used %0d, got %h %0d %0d",
                             e.value, e.status, e.bytes_used, v, st, used);
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;

    wfvd_byte_if  stream_if ();
    wfvd_field_if field_if ();

    field_scoreboard sb;
    int n_beats    = 0;
    int burst_left = 0;

    wire_field_varint_decoder_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stream      (stream_if),
        .field       (field_if)
    );

    always #5 clk = ~clk;

    // Offers one beat, opening a random gap first whenever a burst runs out.
    task automatic send_byte(input item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                stream_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        stream_if.valid     <= 1'b1;
        stream_if.data_byte <= it.data_byte;
        stream_if.mode      <= it.mode;
        stream_if.compact   <= it.compact;
        stream_if.no_data   <= it.no_data;
        do
            @(posedge clk);
        while (!stream_if.ready);
        sb.decode_byte(it);
        n_beats++;
        burst_left--;
    endtask

    // Streams n bytes of one field, first byte in the top used octet of b.
    // At beat abort_at the buffer is reported empty instead and the field ends.
    task automatic send_seq(input logic [2:0] m, input logic c, input int n,
                            input logic [79:0] b, input int abort_at);
        item_t it;
        for (int k = 0; k < n; k++)
        begin
            it.data_byte = b[8 * (n - 1 - k) +: 8];
            it.mode      = (k == 0) ? m : 3'($urandom_range(0, 7));
            it.compact   = (k == 0) ? c : 1'($urandom_range(0, 1));
            it.no_data   = 1'b0;
            if (k == abort_at)
            begin
                it.data_byte = 8'($urandom);
                it.no_data   = 1'b1;
                send_byte(it);
                break;
            end
            send_byte(it);
        end
    endtask

    task automatic send_random_field();
        logic [2:0]  m;
        logic        c;
        logic [79:0] b;
        logic [31:0] len;
        logic [6:0]  p;
        bit          over;
        int          n;
        int          pick;
        m = 3'($urandom_range(0, 7));
        c = 1'($urandom_range(0, 1));
        b = {16'($urandom), 32'($urandom), 32'($urandom)};
        if (m <= MODE_I64)
            n = 1 << m;
        else if (m == MODE_BOOL)
        begin
            n = 1;
            if ($urandom_range(0, 1) == 0)
                b[7:0] = 8'($urandom_range(0, 1));
        end
        else if (m == MODE_ARRAY && !c)
        begin
            n    = 4;
            pick = $urandom_range(0, 4);
            case (pick)
                0:       len = $urandom;
                1:       len = {1'b0, sb.max_len};
                2:       len = {1'b0, sb.max_len} + 32'd1;
                3:       len = $urandom_range(0, sb.max_len);
                default: len = {1'b1, 31'($urandom)};
            endcase
            b[31:0] = len;
        end
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                n = $urandom_range(1, 3);
            else if (pick < 8)
                n = $urandom_range(4, 9);
            else
                n = MAX_VARINT_BYTES;
            over = (pick == 9);
            for (int k = 0; k < n; k++)
            begin
                p = 7'($urandom);
                // Small terminators matter for the zero length and tenth byte rules.
                if (k == n - 1 && (n == 1 || n == MAX_VARINT_BYTES) && $urandom_range(0, 2) == 0)
                    p = 7'($urandom_range(0, 1));
                b[8 * (n - 1 - k) +: 8] = {(k < n - 1) || over, p};
            end
        end
        send_seq(m, c, n, b, ($urandom_range(0, 11) == 0) ? $urandom_range(0, n - 1) : -1);
    endtask

    // Closes any open field, then lets the decoder drain completely.
    task automatic end_phase();
        item_t it;
        if (sb.in_field)
        begin
            it.data_byte = 8'($urandom);
            it.mode      = 3'($urandom_range(0, 7));
            it.compact   = 1'($urandom_range(0, 1));
            it.no_data   = 1'b1;
            send_byte(it);
        end
        stream_if.valid <= 1'b0;
        while (sb.due_fields.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LEN_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.max_len  = v;
    endtask

    // Result side: checks every accepted beat and stalls in changing patterns.
    initial
    begin : field_sink
        int cyc;
        int style;
        int hold;
        cyc   = 0;
        style = 0;
        hold  = 0;
        field_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && field_if.valid && field_if.ready)
                sb.check_field(field_if.value, field_if.status, field_if.bytes_used);
            cyc++;
            if (cyc % 300 == 0)
                style = $urandom_range(0, 3);
            if (hold > 0)
                hold--;
            else if (style == 3 && $urandom_range(0, 9) == 0)
                hold = $urandom_range(1, 12);
            case (style)
                0:       field_if.ready <= 1'b1;
                1:       field_if.ready <= ($urandom_range(0, 99) < 60);
                2:       field_if.ready <= ((cyc % 5) < 2);
                default: field_if.ready <= (hold == 0);
            endcase
        end
    end

    initial
    begin : stimulus
        logic [LEN_W-1:0] limits [5];
        int target;
        sb = new();
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        stream_if.valid     <= 1'b0;
        stream_if.data_byte <= '0;
        stream_if.mode      <= MODE_I8;
        stream_if.compact   <= 1'b0;
        stream_if.no_data   <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed fields under the reset length limit.
        send_seq(MODE_I8, 1'b0, 1, 80'h80, -1);
        send_seq(MODE_I16, 1'b0, 2, 80'h7FFF, -1);
        send_seq(MODE_BOOL, 1'b0, 1, 80'h00, -1);
        send_seq(MODE_BOOL, 1'b0, 1, 80'h01, -1);
        send_seq(MODE_BOOL, 1'b0, 1, 80'hFF, -1);
        send_seq(MODE_VARINT, 1'b0, 1, 80'h03, -1);
        send_seq(MODE_UVARINT, 1'b0, 2, 80'hFF7F, -1);
        send_seq(MODE_ARRAY, 1'b1, 1, 80'h00, -1);
        send_seq(MODE_ARRAY, 1'b0, 4, 80'h0640_0001, -1);
        send_seq(MODE_UVARINT, 1'b0, 1, 80'h00, 0);
        send_seq(MODE_I32, 1'b0, 3, 80'h12_3400, 2);
        send_seq(MODE_UVARINT, 1'b0, 10, 80'hFFFF_FFFF_FFFF_FFFF_FF01, -1);
        end_phase();

        limits = '{31'd0, 31'h7FFF_FFFF, 31'($urandom), 31'($urandom_range(0, 300)),
                   MAX_ARRAY_LENGTH_RST};
        for (int p = 0; p < 5; p++)
        begin
            write_limit(limits[p]);
            target = n_beats + 180;
            while (n_beats < target)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Loose beats with no field structure behind them.
                    repeat ($urandom_range(1, 5))
                        send_byte({8'($urandom), 3'($urandom_range(0, 7)),
                                   1'($urandom_range(0, 1)), ($urandom_range(0, 5) == 0)});
                end
                else
                    send_random_field();
            end
            end_phase();
        end
        repeat (10) @(posedge clk);

        if (sb.due_fields.size() != 0)
        begin
            $display("ERROR: %0d field results never arrived", sb.due_fields.size());
            sb.n_bad += sb.due_fields.size();
        end
        $display("Run covered %0d stream beats and %0d field results", n_beats, sb.n_checked);
        $display("across the reset length limit and five written ones.");
        if (sb.n_bad == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("ERROR: run timed out");
        $display("FAILED: results differ");
        $finish;
    end

endmodule
